// ===== rtl/sflp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp_pkg
// Shared widths, codes and types of the start / ID / length frame parser.
// ----------------------------------------------------------------------------
package sflp_pkg;

    localparam int BYTE_W     = 8;
    localparam int EVENT_W    = 3;
    localparam int SLOT_W     = 2;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;

    // Number of handler ID registers in the configuration map.
    localparam int SLOT_REGS        = 4;
    localparam int MAX_HANDLERS_DEF = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID0        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID1        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID2        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ID3        = 3'd5;

    // Result event codes.
    localparam logic [EVENT_W-1:0] EV_START = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ID    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_LEN   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_DATA  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_STRAY = 3'd4;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  byte_position;
        logic [BYTE_W-1:0]  frame_id;
        logic [BYTE_W-1:0]  frame_length;
        logic               handler_found;
        logic [SLOT_W-1:0]  handler_index;
        logic               frame_done;
        logic               aborted;
    } result_t;

endpackage

// ===== rtl/sflp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp interfaces
// Valid / ready channels of the frame parser: received bytes, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface sflp_rx_if;
    import sflp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sflp_res_if;
    import sflp_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  payload_byte;
    logic [BYTE_W-1:0]  byte_position;
    logic [BYTE_W-1:0]  frame_id;
    logic [BYTE_W-1:0]  frame_length;
    logic               handler_found;
    logic [SLOT_W-1:0]  handler_index;
    logic               frame_done;
    logic               aborted;

    modport source (output valid, output event_res, output payload_byte,
                    output byte_position, output frame_id, output frame_length,
                    output handler_found, output handler_index, output frame_done,
                    output aborted, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input byte_position, input frame_id, input frame_length,
                    input handler_found, input handler_index, input frame_done,
                    input aborted, output ready);
endinterface

interface sflp_cfg_if;
    import sflp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/start_id_length_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_id_length_frame_parser
// Byte-stream parser for frames made of a start byte, an ID, a length and
// that many payload bytes, with a handler ID lookup.
// ----------------------------------------------------------------------------
// Every received byte produces exactly one result item, and the block takes
// one byte per clock cycle while the output is not stalled: the byte is first
// captured in an input register, and in the next stage the frame state is
// updated and the result is written to the output register. Both stages move
// forward together whenever the output register is empty or being drained,
// so a result that waits at the output stops the next byte once the input
// register is full. A byte equal to the programmed start byte always opens
// a new frame (there is no escaping), and flags an abort when a frame was
// still open. A non-start byte outside a frame is reported as a stray byte
// and leaves the state alone. A length of zero completes the frame on the
// length byte itself. The frame ID is compared in parallel against the
// first handler_count slots (saturated to MAX_HANDLERS and to the four
// slot registers), and the lowest matching slot wins. Configuration writes
// are accepted in every cycle and must only be issued while the parser is
// idle.
// ----------------------------------------------------------------------------
module start_id_length_frame_parser #(
    parameter int MAX_HANDLERS = sflp_pkg::MAX_HANDLERS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sflp_rx_if.sink      rx,
    sflp_res_if.source   res,
    sflp_cfg_if.sink     cfg
);
    import sflp_pkg::*;

    // Effective slot limit: the smaller of the parameter and the slot registers.
    localparam int SLOT_LIMIT = (MAX_HANDLERS < SLOT_REGS) ? MAX_HANDLERS : SLOT_REGS;

    // Parser phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    // Configuration registers.
    logic [BYTE_W-1:0]  start_byte_reg;
    logic [COUNT_W-1:0] handler_count_reg;
    logic [BYTE_W-1:0]  handler_id_reg [SLOT_REGS];

    // Input stage.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Frame state.
    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] cur_id_reg, cur_id_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // Output stage.
    logic    res_valid_reg;
    result_t res_reg, res_next;

    // Handler lookup.
    logic [COUNT_W-1:0] slot_lim;
    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic [BYTE_W-1:0]  count_inc;

    logic advance;

    // The pipeline moves when the result register can take a new result.
    assign advance  = !res_valid_reg || res.ready;
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------------
    // Configuration writes. Unknown indexes are ignored.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg    <= '0;
            handler_count_reg <= '0;
            for (int i = 0; i < SLOT_REGS; i++)
            begin
                handler_id_reg[i] <= '0;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index) inside
                CFG_START_BYTE: start_byte_reg    <= cfg.data;
                CFG_COUNT:      handler_count_reg <= cfg.data[COUNT_W-1:0];
                CFG_ID0, CFG_ID1, CFG_ID2, CFG_ID3:
                begin
                    handler_id_reg[SLOT_W'(cfg.index - CFG_ID0)] <= cfg.data;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handler ID lookup: lowest matching slot below the saturated count.
    // ------------------------------------------------------------------------
    always_comb
    begin
        slot_lim = (handler_count_reg > COUNT_W'(SLOT_LIMIT)) ? COUNT_W'(SLOT_LIMIT)
                                                              : handler_count_reg;
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < SLOT_REGS; i++)
        begin
            if (!hit && (COUNT_W'(i) < slot_lim) && (handler_id_reg[i] == in_byte_reg))
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Frame state update and result formation for the byte in the input stage.
    // ------------------------------------------------------------------------
    always_comb
    begin
        phase_next  = phase_reg;
        cur_id_next = cur_id_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        count_inc   = count_reg + 8'd1;
        res_next    = '0;

        if (in_byte_reg == start_byte_reg)
        begin
            // A start byte always opens a fresh frame.
            res_next.event_res = EV_START;
            res_next.aborted   = (phase_reg != PH_IDLE);
            phase_next  = PH_ID;
            cur_id_next = '0;
            len_next    = '0;
            count_next  = '0;
            found_next  = 1'b0;
            slot_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    res_next.event_res = EV_STRAY;
                end
                PH_ID:
                begin
                    cur_id_next = in_byte_reg;
                    found_next  = hit;
                    slot_next   = hit_slot;
                    phase_next  = PH_LEN;
                    res_next.event_res     = EV_ID;
                    res_next.frame_id      = in_byte_reg;
                    res_next.handler_found = hit;
                    res_next.handler_index = hit_slot;
                end
                PH_LEN:
                begin
                    res_next.event_res     = EV_LEN;
                    res_next.frame_id      = cur_id_reg;
                    res_next.frame_length  = in_byte_reg;
                    res_next.handler_found = found_reg;
                    res_next.handler_index = slot_reg;
                    if (in_byte_reg == '0)
                    begin
                        // Zero length completes the frame on the length byte.
                        res_next.frame_done = 1'b1;
                        phase_next  = PH_IDLE;
                        cur_id_next = '0;
                        len_next    = '0;
                        count_next  = '0;
                        found_next  = 1'b0;
                        slot_next   = '0;
                    end
                    else
                    begin
                        len_next   = in_byte_reg;
                        count_next = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res_next.event_res     = EV_DATA;
                    res_next.payload_byte  = in_byte_reg;
                    res_next.byte_position = count_reg;
                    res_next.frame_id      = cur_id_reg;
                    res_next.frame_length  = len_reg;
                    res_next.handler_found = found_reg;
                    res_next.handler_index = slot_reg;
                    count_next = count_inc;
                    if (count_inc == len_reg)
                    begin
                        res_next.frame_done = 1'b1;
                        phase_next  = PH_IDLE;
                        cur_id_next = '0;
                        len_next    = '0;
                        count_next  = '0;
                        found_next  = 1'b0;
                        slot_next   = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control and state registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            cur_id_reg    <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end

            if (advance && in_valid_reg)
            begin
                phase_reg  <= phase_next;
                cur_id_reg <= cur_id_next;
                len_reg    <= len_next;
                count_reg  <= count_next;
                found_reg  <= found_next;
                slot_reg   <= slot_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.event_res     = res_reg.event_res;
    assign res.payload_byte  = res_reg.payload_byte;
    assign res.byte_position = res_reg.byte_position;
    assign res.frame_id      = res_reg.frame_id;
    assign res.frame_length  = res_reg.frame_length;
    assign res.handler_found = res_reg.handler_found;
    assign res.handler_index = res_reg.handler_index;
    assign res.frame_done    = res_reg.frame_done;
    assign res.aborted       = res_reg.aborted;

endmodule

// ===== tb/sv/sflp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp_checker
// Watches the byte, result and configuration channels of the frame parser,
// predicts the result of every accepted byte and compares it with the block.
// ----------------------------------------------------------------------------
module sflp_checker
    import sflp_pkg::*;
#(
    parameter int MAX_HANDLERS = MAX_HANDLERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sflp_rx_if          rx,
    sflp_res_if         res,
    sflp_cfg_if         cfg,
    output int unsigned results_owed,
    output int unsigned mismatch_count
);

    typedef enum logic [1:0] {
        AWAIT_START,
        AWAIT_ID,
        AWAIT_LEN,
        IN_PAYLOAD
    } parse_state_e;

    // Copy of the programmed registers.
    logic [BYTE_W-1:0]  start_byte;
    logic [COUNT_W-1:0] handler_cnt;
    logic [BYTE_W-1:0]  handler_ids [SLOT_REGS];

    // Copy of the frame state.
    parse_state_e       parse_state;
    logic [BYTE_W-1:0]  cur_id;
    logic [BYTE_W-1:0]  cur_len;
    logic [BYTE_W-1:0]  rx_count;
    logic               id_matched;
    logic [SLOT_W-1:0]  id_slot;

    result_t            predicted_results [$];
    result_t            seen_result;
    int unsigned        errors;

    assign seen_result = {res.event_res, res.payload_byte, res.byte_position,
                          res.frame_id, res.frame_length, res.handler_found,
                          res.handler_index, res.frame_done, res.aborted};

    function automatic void clear_frame_state();
        parse_state = AWAIT_START;
        cur_id      = '0;
        cur_len     = '0;
        rx_count    = '0;
        id_matched  = 1'b0;
        id_slot     = '0;
    endfunction

    // Handler slots that take part in the lookup, saturated to the block
    // parameter and to the number of ID registers.
    function automatic int unsigned active_slots();
        int unsigned n;
        n = int'(handler_cnt);
        if (n > MAX_HANDLERS) n = MAX_HANDLERS;
        if (n > SLOT_REGS) n = SLOT_REGS;
        return n;
    endfunction

    function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
        result_t     r;
        int unsigned k;
        int unsigned n;
        r = '0;
        if (b == start_byte) begin
            r.event_res = EV_START;
            r.aborted   = (parse_state != AWAIT_START);
            clear_frame_state();
            parse_state = AWAIT_ID;
        end
        else begin
            case (parse_state)
                AWAIT_START: begin
                    r.event_res = EV_STRAY;
                end
                AWAIT_ID: begin
                    n          = active_slots();
                    cur_id     = b;
                    id_matched = 1'b0;
                    id_slot    = '0;
                    for (k = 0; k < n; k++) begin
                        if (!id_matched && handler_ids[k] == b) begin
                            id_matched = 1'b1;
                            id_slot    = k[SLOT_W-1:0];
                        end
                    end
                    parse_state     = AWAIT_LEN;
                    r.event_res     = EV_ID;
                    r.frame_id      = cur_id;
                    r.handler_found = id_matched;
                    r.handler_index = id_slot;
                end
                AWAIT_LEN: begin
                    cur_len         = b;
                    rx_count        = '0;
                    r.event_res     = EV_LEN;
                    r.frame_id      = cur_id;
                    r.frame_length  = cur_len;
                    r.handler_found = id_matched;
                    r.handler_index = id_slot;
                    if (b == '0) begin
                        r.frame_done = 1'b1;
                        clear_frame_state();
                    end
                    else begin
                        parse_state = IN_PAYLOAD;
                    end
                end
                default: begin
                    r.event_res     = EV_DATA;
                    r.payload_byte  = b;
                    r.byte_position = rx_count;
                    r.frame_id      = cur_id;
                    r.frame_length  = cur_len;
                    r.handler_found = id_matched;
                    r.handler_index = id_slot;
                    rx_count        = rx_count + 8'd1;
                    if (rx_count == cur_len) begin
                        r.frame_done = 1'b1;
                        clear_frame_state();
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_result(input result_t want, input result_t got);
        check_field("event_res", int'(want.event_res), int'(got.event_res));
        check_field("payload_byte", int'(want.payload_byte), int'(got.payload_byte));
        check_field("byte_position", int'(want.byte_position), int'(got.byte_position));
        check_field("frame_id", int'(want.frame_id), int'(got.frame_id));
        check_field("frame_length", int'(want.frame_length), int'(got.frame_length));
        check_field("handler_found", int'(want.handler_found), int'(got.handler_found));
        check_field("handler_index", int'(want.handler_index), int'(got.handler_index));
        check_field("frame_done", int'(want.frame_done), int'(got.frame_done));
        check_field("aborted", int'(want.aborted), int'(got.aborted));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_byte  = '0;
            handler_cnt = '0;
            foreach (handler_ids[i]) handler_ids[i] = '0;
            clear_frame_state();
            predicted_results.delete();
            errors = 0;
            results_owed   <= 0;
            mismatch_count <= 0;
        end
        else begin
            // A result is checked before this edge's byte is predicted; the
            // block never returns a byte's result in the cycle it takes it.
            if (res.valid && res.ready) begin
                if (predicted_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result item with nothing expected, event_res %0d",
                             $time, res.event_res);
                end
                else begin
                    compare_result(predicted_results.pop_front(), seen_result);
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_START_BYTE: start_byte     = cfg.data;
                    CFG_COUNT:      handler_cnt    = cfg.data[COUNT_W-1:0];
                    CFG_ID0:        handler_ids[0] = cfg.data;
                    CFG_ID1:        handler_ids[1] = cfg.data;
                    CFG_ID2:        handler_ids[2] = cfg.data;
                    CFG_ID3:        handler_ids[3] = cfg.data;
                    default: ;
                endcase
            end
            if (rx.valid && rx.ready) begin
                predicted_results.push_back(parse_byte(rx.rx_byte));
            end
            results_owed   <= predicted_results.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ===== tb/sv/tb_start_id_length_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_start_id_length_frame_parser
// Regression of the frame parser: a directed opening and random frame
// traffic under several register settings, with bursty input and a stalling
// result sink; a checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_start_id_length_frame_parser;
    import sflp_pkg::*;

    localparam int HANDLER_SLOTS = MAX_HANDLERS_DEF;

    // Index outside the register map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // Cycles without any accepted item before the run is declared hung. The
    // longest quiet stretch in a good run is the deliberate sink hold-off.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 85;

    // Directed opening, programmed with start byte 8'hA5, three active slots
    // and IDs 8'h10, 8'h22, 8'h10, 8'h33.
    localparam logic [7:0] OPENING_BYTES [25] = '{
        8'h00, 8'hFF,                        // stray bytes while idle
        8'hA5, 8'h22, 8'h00,                 // zero length frame, slot 1
        8'hA5, 8'h10, 8'h02, 8'h00, 8'hFF,   // slot 0 wins over slot 2
        8'hA5, 8'h33, 8'h02, 8'h11,          // ID only in an inactive slot
        8'hA5, 8'h44, 8'hFF, 8'h01,          // restart inside a payload
        8'hA5, 8'hA5, 8'h7E, 8'hA5,          // restart at the ID and length
        8'h10, 8'h01, 8'h80                  // completes the last frame
    };

    typedef enum int {
        SINK_FULL,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_PERIODIC,
        SINK_SPARSE
    } sink_mode_e;

    typedef enum int {
        FRAME_GOOD,
        FRAME_CUT,
        FRAME_STRAY,
        FRAME_NOISE,
        FRAME_LONG
    } frame_kind_e;

    logic clk;
    logic rst_n;

    sflp_rx_if  rx_ch ();
    sflp_res_if res_ch ();
    sflp_cfg_if cfg_ch ();

    int unsigned results_owed;
    int unsigned mismatch_count;

    // Settings last programmed, used to shape well-formed frames.
    logic [7:0]  cur_start;
    logic [7:0]  cur_ids [HANDLER_SLOTS];

    int unsigned burst_left;
    int unsigned items_sent;
    int unsigned idle_cycles;
    logic        stall_req;

    start_id_length_frame_parser #(
        .MAX_HANDLERS (HANDLER_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    sflp_checker #(
        .MAX_HANDLERS (HANDLER_SLOTS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .res            (res_ch),
        .cfg            (cfg_ch),
        .results_owed   (results_owed),
        .mismatch_count (mismatch_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Byte source helpers
    // ------------------------------------------------------------------------

    // Offers one byte and returns at the edge where it is accepted. The
    // source works in bursts; between bursts valid drops for a random gap,
    // and now and then a long burst runs with no gap at all.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        items_sent++;
    endtask

    function automatic logic [7:0] not_start_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == cur_start);
        return b;
    endfunction

    // Mostly a registered ID so that the lookup finds something.
    function automatic logic [7:0] pick_id();
        logic [7:0] b;
        b = cur_ids[$urandom_range(0, HANDLER_SLOTS - 1)];
        if ($urandom_range(0, 9) < 4 || b == cur_start) b = not_start_byte();
        return b;
    endfunction

    // Short frames dominate; a length equal to the start byte would restart
    // the frame, so it is drawn again.
    function automatic logic [7:0] pick_length();
        logic [7:0]  len;
        int unsigned roll;
        do begin
            roll = $urandom_range(0, 9);
            if (roll < 6) len = 8'($urandom_range(0, 4));
            else if (roll < 9) len = 8'($urandom_range(5, 16));
            else len = 8'($urandom_range(17, 40));
        end while (len == cur_start);
        return len;
    endfunction

    // Payload content; once in a while it hits the start byte, which has no
    // escape and restarts the frame.
    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 32) == 0) return 8'($urandom_range(0, 255));
        return not_start_byte();
    endfunction

    // Lowers valid and waits until the sink has taken every predicted result.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Writes the whole register map back to back, plus one write to an
    // unmapped index. Called only with nothing in flight in the block.
    task automatic program_parser(input logic [7:0] start, input logic [2:0] count,
                                  input logic [7:0] id0, input logic [7:0] id1,
                                  input logic [7:0] id2, input logic [7:0] id3);
        write_reg(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
        write_reg(CFG_START_BYTE, start);
        write_reg(CFG_COUNT, 8'(count));
        write_reg(CFG_ID0, id0);
        write_reg(CFG_ID1, id1);
        write_reg(CFG_ID2, id2);
        write_reg(CFG_ID3, id3);
        cfg_ch.valid <= 1'b0;
        cur_start  = start;
        cur_ids[0] = id0;
        cur_ids[1] = id1;
        cur_ids[2] = id2;
        cur_ids[3] = id3;
    endtask

    // Waits out the pipeline so the next register writes land on an idle
    // block; the parser itself has been left between frames.
    task automatic settle_for_config();
        drain_results();
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random frame traffic
    // ------------------------------------------------------------------------

    task automatic send_frame();
        int unsigned  roll;
        int unsigned  k;
        int unsigned  n;
        logic [7:0]   len;
        frame_kind_e  kind;
        roll = $urandom_range(0, 99);
        if (roll < 60) kind = FRAME_GOOD;
        else if (roll < 72) kind = FRAME_CUT;
        else if (roll < 84) kind = FRAME_STRAY;
        else if (roll < 96) kind = FRAME_NOISE;
        else kind = FRAME_LONG;
        case (kind)
            FRAME_GOOD: begin
                len = pick_length();
                send_byte(cur_start);
                send_byte(pick_id());
                send_byte(len);
                for (k = 0; k < len; k++) send_byte(pick_payload());
            end
            FRAME_CUT: begin
                // Header broken off; whatever follows either restarts the
                // frame with an abort or is taken as header or payload.
                n = $urandom_range(0, 2);
                send_byte(cur_start);
                if (n > 0) send_byte(pick_id());
                if (n > 1) send_byte(pick_length());
            end
            FRAME_STRAY: begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) send_byte(not_start_byte());
            end
            FRAME_NOISE: begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                // A declared length near the top of the range, left open so
                // that a later start byte aborts it.
                do len = 8'($urandom_range(200, 255)); while (len == cur_start);
                send_byte(cur_start);
                send_byte(pick_id());
                send_byte(len);
                n = $urandom_range(10, 30);
                for (k = 0; k < n; k++) send_byte(not_start_byte());
            end
        endcase
    endtask

    // One phase of random traffic. The sink hold-off and the full drain are
    // triggered once the phase has sent the given number of items; a
    // negative value leaves them out. The phase closes with a complete
    // one-byte frame so the parser is between frames afterwards.
    task automatic run_random(input int n, input int stall_at, input int pause_at);
        int unsigned base;
        base = items_sent;
        while (items_sent - base < n) begin
            if (stall_at >= 0 && items_sent - base >= stall_at) begin
                stall_req <= 1'b1;
                stall_at = -1;
            end
            if (pause_at >= 0 && items_sent - base >= pause_at) begin
                drain_results();
                pause_at = -1;
            end
            send_frame();
        end
        send_byte(cur_start);
        send_byte(pick_id());
        send_byte(8'd1);
        send_byte(not_start_byte());
    endtask

    // ------------------------------------------------------------------------
    // Result sink: ready follows a random pattern that changes after a random
    // span of cycles, and once, on request, stays low long enough for the block to
    // fill up and push back on its input.
    // ------------------------------------------------------------------------
    initial begin
        sink_mode_e  mode;
        int unsigned span;
        int unsigned period;
        int unsigned c;
        logic        r;
        logic        stall_done;
        stall_done = 1'b0;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            mode   = sink_mode_e'($urandom_range(0, 4));
            span   = $urandom_range(10, 80);
            period = $urandom_range(2, 5);
            for (c = 0; c < span; c++) begin
                if (stall_req && !stall_done) begin
                    res_ch.ready <= 1'b0;
                    repeat (SINK_HOLD_CYCLES) @(posedge clk);
                    stall_done = 1'b1;
                end
                case (mode)
                    SINK_FULL:     r = 1'b1;
                    SINK_COIN:     r = 1'($urandom_range(0, 1));
                    SINK_MOSTLY:   r = ($urandom_range(0, 99) < 85);
                    SINK_PERIODIC: r = ((c % period) == 0);
                    default:       r = ($urandom_range(0, 99) < 20);
                endcase
                res_ch.ready <= r;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted item on any channel restarts the count.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("start_id_length_frame_parser regression: fail");
                $finish;
            end
            else begin
                idle_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        int unsigned k;
        logic [7:0]  id0;
        logic [7:0]  id1;
        rst_n          <= 1'b0;
        rx_ch.valid    <= 1'b0;
        rx_ch.rx_byte  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        stall_req      <= 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: strays, zero length, first-match lookup, an ID
        // in a slot beyond the count, and a restart in every frame phase.
        program_parser(8'hA5, 3'd3, 8'h10, 8'h22, 8'h10, 8'h33);
        foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

        // Start byte at the bottom of the range and no active handlers.
        settle_for_config();
        program_parser(8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        run_random(ITEMS_PER_PHASE, -1, -1);

        // Start byte at the top, all four slots with a duplicate, and the
        // long sink hold-off while bytes keep coming.
        settle_for_config();
        program_parser(8'hFF, 3'd4, 8'h00, 8'h7F, 8'h80, 8'h7F);
        run_random(ITEMS_PER_PHASE, 20, -1);

        // Largest count value, which saturates; the source also pauses once
        // until every result is out.
        settle_for_config();
        program_parser(8'h7E, 3'd7, 8'h01, 8'h02, 8'h03, 8'h04);
        run_random(ITEMS_PER_PHASE, -1, 40);

        // A single active slot, with the same ID repeated in the others.
        settle_for_config();
        program_parser(8'h5A, 3'd1, 8'hC3, 8'hC3, 8'hC3, 8'hC3);
        run_random(ITEMS_PER_PHASE, -1, -1);

        // Random settings, each with a duplicated ID pair.
        for (k = 0; k < 2; k++) begin
            settle_for_config();
            id0 = 8'($urandom_range(0, 255));
            id1 = ($urandom_range(0, 1) == 1) ? id0 : 8'($urandom_range(0, 255));
            program_parser(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                           id0, id1, 8'($urandom_range(0, 255)), id0);
            run_random(ITEMS_PER_PHASE, -1, -1);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("start_id_length_frame_parser regression: pass");
        end
        else begin
            $display("start_id_length_frame_parser regression: fail");
        end
        $finish;
    end

endmodule
